// File: rtl/frpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frpr_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;

  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hFF;

  localparam logic OP_LINK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic link_en;     // process one link byte
    logic emit_empty;  // present the empty result of a read request
    logic read_clear;  // restart the read beat counter
    logic read_beat;   // fetch and present one payload byte
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ring_empty;
    logic read_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/frpr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module frpr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               op_i,
  input  frpr_pkg::dp_status_t    status_i,
  output frpr_pkg::ctrl_cmd_t     cmd_o,
  output logic                    busy_o
);
  import frpr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_q;
  logic state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (op_i == OP_LINK) begin
            cmd_o.link_en = 1'b1;
          end else if (status_i.ring_empty) begin
            cmd_o.emit_empty = 1'b1;
          end else begin
            cmd_o.read_clear = 1'b1;
            state_d          = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.read_beat = 1'b1;
        if (status_i.read_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == ST_READ);

endmodule

`default_nettype wire

// File: rtl/frpr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module frpr_datapath #(
  parameter int PAYLOAD_BYTES = 8,
  parameter int RING_SLOTS    = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  frpr_pkg::ctrl_cmd_t            cmd_i,
  output frpr_pkg::dp_status_t           status_o,
  input  wire logic [frpr_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [frpr_pkg::BYTE_W-1:0] cfg_wdata_i,
  output logic                           out_strobe_o,
  output logic                           available_o,
  output logic [frpr_pkg::BYTE_W-1:0]    out_byte_o,
  output logic [frpr_pkg::POS_W-1:0]     byte_position_o,
  output logic                           last_o
);
  import frpr_pkg::*;

  localparam int DEPTH  = RING_SLOTS * PAYLOAD_BYTES;
  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CNT_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_SLOTS - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(PAYLOAD_BYTES - 1);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CHECK   = 2'd2;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_LAST) ? '0 : SLOT_W'(s + 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0]  c);
    slot_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(PAYLOAD_BYTES)) + ADDR_W'(c);
  endfunction

  logic [BYTE_W-1:0] start_byte_q;
  logic [1:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  wr_cnt_q, wr_cnt_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
  logic [SLOT_W-1:0] rd_last_slot_q, rd_last_slot_d;
  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic [SLOT_W-1:0] rd_slot;
  logic              mem_we;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic              strobe_q, strobe_d;
  logic              avail_q, avail_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              last_q, last_d;

  assign rd_slot             = next_slot(rd_last_slot_q);
  assign status_o.ring_empty = (rd_slot == wr_slot_q);
  assign status_o.read_last  = (rd_cnt_q == CNT_LAST);

  always_comb begin
    phase_d        = phase_q;
    wr_cnt_d       = wr_cnt_q;
    sum_d          = sum_q;
    wr_slot_d      = wr_slot_q;
    rd_last_slot_d = rd_last_slot_q;
    mem_we         = 1'b0;
    if (cmd_i.link_en) begin
      case (phase_q)
        PH_PAYLOAD: begin
          mem_we   = 1'b1;
          sum_d    = sum_q + rx_byte_i;
          wr_cnt_d = CNT_W'(wr_cnt_q + 1'b1);
          if (wr_cnt_q == CNT_LAST) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          // A good checksum commits the slot; a full ring drops its oldest packet.
          if (sum_q == rx_byte_i) begin
            wr_slot_d = next_slot(wr_slot_q);
            if (next_slot(wr_slot_q) == rd_slot) begin
              rd_last_slot_d = rd_slot;
            end
          end
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == start_byte_q) begin
            phase_d  = PH_PAYLOAD;
            wr_cnt_d = '0;
            sum_d    = '0;
          end
        end
      endcase
    end
    if (cmd_i.read_beat && status_o.read_last) begin
      rd_last_slot_d = rd_slot;
    end
  end

  always_comb begin
    rd_cnt_d = rd_cnt_q;
    if (cmd_i.read_clear) begin
      rd_cnt_d = '0;
    end else if (cmd_i.read_beat) begin
      rd_cnt_d = CNT_W'(rd_cnt_q + 1'b1);
    end
  end

  always_comb begin
    strobe_d = 1'b0;
    avail_d  = 1'b0;
    pos_d    = '0;
    last_d   = 1'b0;
    if (cmd_i.emit_empty) begin
      strobe_d = 1'b1;
      last_d   = 1'b1;
    end else if (cmd_i.read_beat) begin
      strobe_d = 1'b1;
      avail_d  = 1'b1;
      pos_d    = POS_W'(rd_cnt_q);
      last_d   = status_o.read_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q   <= START_BYTE_RESET;
      phase_q        <= PH_HUNT;
      wr_cnt_q       <= '0;
      sum_q          <= '0;
      wr_slot_q      <= '0;
      rd_last_slot_q <= SLOT_LAST;
      rd_cnt_q       <= '0;
      strobe_q       <= 1'b0;
      avail_q        <= 1'b0;
      pos_q          <= '0;
      last_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_byte_q <= cfg_wdata_i;
      end
      phase_q        <= phase_d;
      wr_cnt_q       <= wr_cnt_d;
      sum_q          <= sum_d;
      wr_slot_q      <= wr_slot_d;
      rd_last_slot_q <= rd_last_slot_d;
      rd_cnt_q       <= rd_cnt_d;
      strobe_q       <= strobe_d;
      avail_q        <= avail_d;
      pos_q          <= pos_d;
      last_q         <= last_d;
    end
  end

  // Packet store with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_addr(wr_slot_q, wr_cnt_q)] <= rx_byte_i;
    end
    if (cmd_i.read_beat) begin
      rdata_q <= mem_q[slot_addr(rd_slot, rd_cnt_q)];
    end
  end

  assign out_strobe_o    = strobe_q;
  assign available_o     = avail_q;
  assign out_byte_o      = avail_q ? rdata_q : '0;
  assign byte_position_o = pos_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

// File: rtl/framed_packet_receiver_ring_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Start-byte framed packet receiver with a ring of packet slots. A link byte
// (op 0) is taken with busy low and never produces a result. A read request on
// an empty ring produces its single empty result in the cycle after the
// transfer, with busy staying low. A read request with a packet pending holds
// busy in the read state and streams one payload byte per cycle, the first one
// after the read state is entered and the store read is registered; the rate
// is set by the single read port of the packet store. Results cannot be stalled:
// each one is valid only in the cycle its strobe is high.

module framed_packet_receiver_ring_core #(
  parameter int PAYLOAD_BYTES = 8,
  parameter int RING_SLOTS    = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        op_i,
  input  wire logic [frpr_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [frpr_pkg::BYTE_W-1:0] cfg_wdata_i,
  output logic                             out_strobe_o,
  output logic                             available_o,
  output logic [frpr_pkg::BYTE_W-1:0]      out_byte_o,
  output logic [frpr_pkg::POS_W-1:0]       byte_position_o,
  output logic                             last_o
);
  import frpr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  frpr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .op_i     (op_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  frpr_datapath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .RING_SLOTS    (RING_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .rx_byte_i       (rx_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_strobe_o    (out_strobe_o),
    .available_o     (available_o),
    .out_byte_o      (out_byte_o),
    .byte_position_o (byte_position_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// File: rtl/frpr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module frpr_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start_i,
  input wire logic                        busy_o,
  input wire logic                        op_i,
  input wire logic                        out_strobe_o,
  input wire logic                        available_o,
  input wire logic [frpr_pkg::BYTE_W-1:0] out_byte_o,
  input wire logic [frpr_pkg::POS_W-1:0]  byte_position_o,
  input wire logic                        last_o
);
  import frpr_pkg::*;

  // A result only follows an accepted transfer or a busy read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> ($past(start_i && !busy_o) || $past(busy_o)))
    else $error("result without a preceding transfer or read");

  // A link byte never causes a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == OP_LINK) |=> !out_strobe_o)
    else $error("link byte produced a result");

  // The empty result is a single, final, all-zero item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !available_o) |->
      (last_o && out_byte_o == '0 && byte_position_o == '0))
    else $error("malformed empty result");

  // Packet bytes stream back to back with rising positions until the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && available_o && !last_o) |=>
      (out_strobe_o && available_o &&
       byte_position_o == POS_W'($past(byte_position_o) + 1'b1)))
    else $error("packet stream broken before its last byte");

endmodule

bind framed_packet_receiver_ring_core frpr_checker u_frpr_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import frpr_pkg::*;

  localparam int PAYLOAD_BYTES = 8;
  localparam int RING_SLOTS    = 4;
  localparam int SLOT_W        = $clog2(RING_SLOTS);
  localparam int CFG_QUIET     = 4;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_ITEMS   = 80;

  typedef enum logic [1:0] {PH_HUNT, PH_PAYLOAD, PH_CHECKSUM} frame_phase_e;
  typedef enum logic [1:0] {CMD_LINK, CMD_READ, CMD_CFG} cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [BYTE_W-1:0] data;
  } link_cmd_t;

  typedef struct packed {
    logic              available;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  byte_position;
    logic              last;
  } rx_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic op_i = OP_LINK;
  logic [BYTE_W-1:0] rx_byte_i = '0;
  logic cfg_we_i = 1'b0;
  logic [BYTE_W-1:0] cfg_wdata_i = '0;
  logic busy_o;
  logic out_strobe_o;
  logic available_o;
  logic [BYTE_W-1:0] out_byte_o;
  logic [POS_W-1:0] byte_position_o;
  logic last_o;

  link_cmd_t  cmd_queue[$];
  rx_result_t result_queue[$];
  int unsigned errors = 0;
  int unsigned data_items_queued = 0;
  int unsigned transfers_seen = 0;

  // Shadow copy of the framer and ring state.
  logic [BYTE_W-1:0] shadow_start = START_BYTE_RESET;
  frame_phase_e      shadow_phase = PH_HUNT;
  int unsigned       shadow_count = 0;
  logic [BYTE_W-1:0] shadow_sum = '0;
  logic [BYTE_W-1:0] shadow_store [RING_SLOTS][PAYLOAD_BYTES];
  logic [SLOT_W-1:0] shadow_wr_slot = '0;
  logic [SLOT_W-1:0] shadow_rd_last = SLOT_W'(RING_SLOTS - 1);

  int unsigned n_commits = 0;
  int unsigned n_bad_sums = 0;
  int unsigned n_drops = 0;
  int unsigned n_packet_reads = 0;
  int unsigned n_empty_reads = 0;
  int unsigned n_cfg_writes = 0;

  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_cycles = 0;

  framed_packet_receiver_ring_core #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .RING_SLOTS   (RING_SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .rx_byte_i      (rx_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_strobe_o   (out_strobe_o),
    .available_o    (available_o),
    .out_byte_o     (out_byte_o),
    .byte_position_o(byte_position_o),
    .last_o         (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(RING_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Advances the shadow state by one transfer and queues the results it causes.
  task automatic ring_predict(input logic op, input logic [BYTE_W-1:0] b);
    rx_result_t        res;
    logic [SLOT_W-1:0] slot;
    if (op == OP_LINK) begin
      case (shadow_phase)
        PH_PAYLOAD: begin
          shadow_store[shadow_wr_slot][shadow_count] = b;
          shadow_sum = shadow_sum + b;
          shadow_count++;
          if (shadow_count >= PAYLOAD_BYTES) shadow_phase = PH_CHECKSUM;
        end
        PH_CHECKSUM: begin
          if (shadow_sum == b) begin
            n_commits++;
            shadow_wr_slot = ring_next(shadow_wr_slot);
            if (shadow_wr_slot == ring_next(shadow_rd_last)) begin
              shadow_rd_last = ring_next(shadow_rd_last);
              n_drops++;
            end
          end else begin
            n_bad_sums++;
          end
          shadow_phase = PH_HUNT;
        end
        default: begin
          shadow_phase = PH_HUNT;
          if (b == shadow_start) begin
            shadow_phase = PH_PAYLOAD;
            shadow_count = 0;
            shadow_sum = '0;
          end
        end
      endcase
    end else begin
      slot = ring_next(shadow_rd_last);
      if (slot == shadow_wr_slot) begin
        res = '{available: 1'b0, out_byte: '0, byte_position: '0, last: 1'b1};
        result_queue.push_back(res);
        n_empty_reads++;
      end else begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          res.available = 1'b1;
          res.out_byte = shadow_store[slot][i];
          res.byte_position = POS_W'(i);
          res.last = (i == PAYLOAD_BYTES - 1);
          result_queue.push_back(res);
        end
        shadow_rd_last = slot;
        n_packet_reads++;
      end
    end
  endtask

  // Driver: works off cmd_queue; register writes wait until the block is quiet.
  always @(posedge clk_i or negedge rst_ni) begin
    logic              took;
    logic              nxt_start;
    logic              nxt_op;
    logic [BYTE_W-1:0] nxt_byte;
    logic              nxt_we;
    logic [BYTE_W-1:0] nxt_wdata;
    if (!rst_ni) begin
      start_i <= 1'b0;
      op_i <= OP_LINK;
      rx_byte_i <= '0;
      cfg_we_i <= 1'b0;
      cfg_wdata_i <= '0;
      gap_left = 0;
      quiet_cycles = 0;
    end else begin
      took = start_i && !busy_o;
      nxt_start = start_i;
      nxt_op = op_i;
      nxt_byte = rx_byte_i;
      nxt_we = 1'b0;
      nxt_wdata = cfg_wdata_i;
      if (took || busy_o || start_i || result_queue.size() != 0) quiet_cycles = 0;
      else if (quiet_cycles < 1000) quiet_cycles++;
      if (took) begin
        nxt_start = 1'b0;
        gap_left = pick_gap();
      end
      if (!(start_i && !took)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() != 0) begin
          if (cmd_queue[0].kind == CMD_CFG) begin
            if (quiet_cycles >= CFG_QUIET) begin
              nxt_we = 1'b1;
              nxt_wdata = cmd_queue[0].data;
              void'(cmd_queue.pop_front());
              quiet_cycles = 0;
            end
          end else begin
            nxt_start = 1'b1;
            nxt_op = (cmd_queue[0].kind == CMD_READ) ? OP_READ : OP_LINK;
            nxt_byte = cmd_queue[0].data;
            void'(cmd_queue.pop_front());
          end
        end
      end
      start_i <= nxt_start;
      op_i <= nxt_op;
      rx_byte_i <= nxt_byte;
      cfg_we_i <= nxt_we;
      cfg_wdata_i <= nxt_wdata;
    end
  end

  // Monitor: checks the result of this cycle first, then predicts the new transfer.
  always @(posedge clk_i) begin
    rx_result_t want;
    if (rst_ni) begin
      if (out_strobe_o) begin
        if (result_queue.size() == 0) begin
          $error("result with nothing pending: available %0d out_byte %0h pos %0d last %0d",
                 available_o, out_byte_o, byte_position_o, last_o);
          errors++;
        end else begin
          want = result_queue.pop_front();
          if (available_o !== want.available) begin
            $error("available: expected %0d, actual %0d", want.available, available_o);
            errors++;
          end
          if (out_byte_o !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte_o);
            errors++;
          end
          if (byte_position_o !== want.byte_position) begin
            $error("byte_position: expected %0d, actual %0d",
                   want.byte_position, byte_position_o);
            errors++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_o);
            errors++;
          end
        end
      end
      if (cfg_we_i) begin
        shadow_start = cfg_wdata_i;
        n_cfg_writes++;
      end
      if (start_i && !busy_o) begin
        ring_predict(op_i, rx_byte_i);
        transfers_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || out_strobe_o || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("framed_packet_receiver_ring_core verification failed");
        $finish;
      end
    end
  end

  task automatic queue_link(input logic [BYTE_W-1:0] b);
    cmd_queue.push_back('{kind: CMD_LINK, data: b});
    data_items_queued++;
  endtask

  task automatic queue_read(input logic [BYTE_W-1:0] b);
    cmd_queue.push_back('{kind: CMD_READ, data: b});
    data_items_queued++;
  endtask

  // Start byte, len random payload bytes, then a checksum when with_sum is set.
  task automatic queue_frame(input logic [BYTE_W-1:0] sb, input int unsigned len,
                             input logic with_sum, input logic corrupt);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    sum = '0;
    queue_link(sb);
    for (int i = 0; i < len; i++) begin
      b = $urandom_range(0, 255);
      sum = sum + b;
      queue_link(b);
    end
    if (with_sum) queue_link(corrupt ? sum ^ BYTE_W'($urandom_range(1, 255)) : sum);
  endtask

  initial begin
    logic [BYTE_W-1:0] fixed_payload [PAYLOAD_BYTES];
    logic [BYTE_W-1:0] phase_start [6];
    int unsigned       read_pct [6];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] sb;
    int unsigned       n;
    int unsigned       r;
    int unsigned       len;
    int unsigned       k;

    fixed_payload = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
    read_pct = '{15, 35, 55, 25, 45, 65};
    phase_start[0] = 8'h00;
    phase_start[1] = 8'hFF;
    phase_start[2] = $urandom_range(0, 255);
    phase_start[3] = $urandom_range(0, 255);
    phase_start[4] = 8'h80;
    phase_start[5] = $urandom_range(0, 255);

    // Directed part with the reset start byte: empty read, a good frame that
    // carries the start byte as data, then a frame with a bad checksum.
    queue_read(8'hFF);
    queue_link(8'h00);
    sum = '0;
    queue_link(START_BYTE_RESET);
    foreach (fixed_payload[i]) begin
      queue_link(fixed_payload[i]);
      sum = sum + fixed_payload[i];
    end
    queue_link(sum);
    queue_read(8'h00);
    sum = '0;
    queue_link(START_BYTE_RESET);
    foreach (fixed_payload[i]) begin
      queue_link(~fixed_payload[i]);
      sum = sum + ~fixed_payload[i];
    end
    queue_link(sum ^ 8'h01);
    queue_read(8'h5A);

    // Random phases, each with its own start byte and read density.
    for (int p = 0; p < 6; p++) begin
      sb = phase_start[p];
      cmd_queue.push_back('{kind: CMD_CFG, data: sb});
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < read_pct[p]) begin
          queue_read($urandom_range(0, 255));
          n++;
        end else if (r < read_pct[p] + 12) begin
          queue_link($urandom_range(0, 255));
        end else if (r < read_pct[p] + 18) begin
          len = $urandom_range(0, PAYLOAD_BYTES - 1);
          queue_frame(sb, len, 1'b0, 1'b0);
          n += len + 1;
        end else begin
          queue_frame(sb, PAYLOAD_BYTES, 1'b1, $urandom_range(0, 9) == 0);
          n += PAYLOAD_BYTES + 2;
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (transfers_seen < data_items_queued) @(posedge clk_i);
    k = 0;
    while (result_queue.size() != 0 && k < 200) begin
      @(posedge clk_i);
      k++;
    end
    repeat (20) @(posedge clk_i);
    if (result_queue.size() != 0) begin
      $error("%0d results never arrived", result_queue.size());
      errors++;
    end

    $display("Covered %0d transfers and %0d start byte writes: %0d packets committed,",
             transfers_seen, n_cfg_writes, n_commits);
    $display("%0d bad checksums, %0d overwritten, %0d packets read, %0d empty reads.",
             n_bad_sums, n_drops, n_packet_reads, n_empty_reads);
    if (errors == 0) begin
      $display("framed_packet_receiver_ring_core verification clean");
    end else begin
      $display("framed_packet_receiver_ring_core verification failed");
    end
    $finish;
  end

endmodule
